### hw/rtl/smm_pkg.sv
package smm_pkg;

  localparam int IDX_W      = 3;
  localparam int ELEM_W     = 16;
  localparam int MUL_W      = 32;
  localparam int SUM_W      = 48;
  localparam int SIZE_W     = 4;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = 2;

  typedef logic [1:0] action_t;

  localparam action_t ACT_LOAD_A  = 2'd0;
  localparam action_t ACT_LOAD_B  = 2'd1;
  localparam action_t ACT_COMPUTE = 2'd2;

  typedef struct packed {
    action_t                  kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] data;
  } cmd_t;

endpackage

### hw/rtl/square_matrix_multiply.sv
// Square matrix multiply, C = A x B on signed Q8.8 elements, Q32.16 results.
// Input queue: drive action/row/col/element_value with push; a request is
// taken on a clock edge with push high and full low. Action 0 loads A, 1 loads
// B, 2 starts a compute; loads outside the store and action 3 are dropped.
// Output queue: while empty is low the oldest result is on out_row, out_col,
// product_value and last_of_matrix; pop high takes it.
// Config: matrix_size_we writes matrix_size (0 acts as 1, above MAX_SIZE acts
// as MAX_SIZE); write it only while the block is idle.
// Loads go through a four-entry command queue and are written one per cycle
// while no compute runs. A compute of size n walks every element of C through
// one multiplier: n reads of A and B, a multiply, an accumulate and an output
// step per element, one element at a time, set by the single read port of
// each element store. Requests keep queuing while the compute runs, and a
// stalled receiver holds the walk at the output register.
// Reset empties both queues and sets matrix_size to 8; the element stores
// keep whatever they held and must be loaded before use.
module square_matrix_multiply #(
  parameter int MAX_SIZE = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action,
  input  logic [smm_pkg::IDX_W-1:0]         row,
  input  logic [smm_pkg::IDX_W-1:0]         col,
  input  logic signed [smm_pkg::ELEM_W-1:0] element_value,
  output logic                              empty,
  input  logic                              pop,
  output logic [smm_pkg::IDX_W-1:0]         out_row,
  output logic [smm_pkg::IDX_W-1:0]         out_col,
  output logic signed [smm_pkg::SUM_W-1:0]  product_value,
  output logic                              last_of_matrix,
  input  logic                              matrix_size_we,
  input  logic [smm_pkg::SIZE_W-1:0]        matrix_size
);
  import smm_pkg::*;

  logic [SIZE_W-1:0] size_reg;
  logic              q_empty;
  logic              q_pop;
  cmd_t              q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_W'(8);
    end else if (matrix_size_we) begin
      size_reg <= matrix_size;
    end
  end

  smm_front #(.MAX_SIZE(MAX_SIZE)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .row           (row),
    .col           (col),
    .element_value (element_value),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_cmd         (q_cmd)
  );

  smm_back #(.MAX_SIZE(MAX_SIZE)) u_back (
    .clk            (clk),
    .rst            (rst),
    .matrix_size    (size_reg),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_cmd          (q_cmd),
    .empty          (empty),
    .pop            (pop),
    .out_row        (out_row),
    .out_col        (out_col),
    .product_value  (product_value),
    .last_of_matrix (last_of_matrix)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command queue read while empty");

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_matrix) |-> (out_row == out_col))
    else $error("last result not on the diagonal");
`endif

endmodule

### hw/rtl/smm_front.sv
module smm_front #(
  parameter int MAX_SIZE = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  smm_pkg::action_t             action,
  input  logic [smm_pkg::IDX_W-1:0]    row,
  input  logic [smm_pkg::IDX_W-1:0]    col,
  input  logic signed [smm_pkg::ELEM_W-1:0] element_value,
  output logic                         q_empty,
  input  logic                         q_pop,
  output smm_pkg::cmd_t                q_cmd
);
  import smm_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                  accept;
  logic                  in_store;
  logic                  keep;
  logic                  wr;
  logic                  rd;

  assign full     = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign q_empty  = (count == '0);
  assign accept   = push && !full;
  // loads outside the store and unused actions are dropped here
  assign in_store = ({1'b0, row} < (IDX_W+1)'(MAX_SIZE)) &&
                    ({1'b0, col} < (IDX_W+1)'(MAX_SIZE));
  assign keep     = (action == ACT_COMPUTE) ||
                    (((action == ACT_LOAD_A) || (action == ACT_LOAD_B)) && in_store);
  assign wr       = accept && keep;
  assign rd       = q_pop && !q_empty;
  assign q_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= '{kind: action, row: row, col: col, data: element_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/smm_back.sv
module smm_back #(
  parameter int MAX_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [smm_pkg::SIZE_W-1:0]      matrix_size,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  smm_pkg::cmd_t                   q_cmd,
  output logic                            empty,
  input  logic                            pop,
  output logic [smm_pkg::IDX_W-1:0]       out_row,
  output logic [smm_pkg::IDX_W-1:0]       out_col,
  output logic signed [smm_pkg::SUM_W-1:0] product_value,
  output logic                            last_of_matrix
);
  import smm_pkg::*;

  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  logic [1:0]               state;
  logic [IDX_W-1:0]         i;
  logic [IDX_W-1:0]         j;
  logic [IDX_W-1:0]         k;
  logic [SIZE_W-1:0]        n_cur;
  logic [SIZE_W-1:0]        size_eff;
  logic [IDX_W-1:0]         n_last;
  logic                     issuing;
  logic                     issue;
  logic                     s1_valid, s1_first, s1_last;
  logic                     s2_valid, s2_first, s2_last;
  logic signed [ELEM_W-1:0] a_rd;
  logic signed [ELEM_W-1:0] b_rd;
  logic signed [MUL_W-1:0]  prod;
  logic signed [SUM_W-1:0]  acc;
  logic                     out_valid;
  logic                     out_free;
  logic                     out_take;
  logic                     start;
  logic                     a_we;
  logic                     b_we;
  logic [5:0]               wa_full;
  logic [5:0]               ra_full;
  logic [5:0]               rb_full;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        ra;
  logic [ADDR_W-1:0]        rb;

  always_comb begin
    priority if (matrix_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(MAX_SIZE)) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end else begin
      size_eff = matrix_size;
    end
  end

  assign n_last   = IDX_W'(n_cur - 1'b1);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign a_we     = q_pop && (q_cmd.kind == ACT_LOAD_A);
  assign b_we     = q_pop && (q_cmd.kind == ACT_LOAD_B);
  assign start    = q_pop && (q_cmd.kind == ACT_COMPUTE);
  assign issue    = (state == ST_RUN) && issuing;
  assign out_take = pop && out_valid;
  assign out_free = !out_valid || pop;

  assign wa_full = 6'(q_cmd.row) * 6'(MAX_SIZE) + 6'(q_cmd.col);
  assign ra_full = 6'(i) * 6'(MAX_SIZE) + 6'(k);
  assign rb_full = 6'(k) * 6'(MAX_SIZE) + 6'(j);
  assign waddr   = wa_full[ADDR_W-1:0];
  assign ra      = ra_full[ADDR_W-1:0];
  assign rb      = rb_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[waddr] <= q_cmd.data;
    end
    a_rd <= mem_a[ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[waddr] <= q_cmd.data;
    end
    b_rd <= mem_b[rb];
  end

  // multiply-accumulate datapath
  always_ff @(posedge clk) begin
    s1_first <= (k == '0);
    s1_last  <= (k == n_last);
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= a_rd * b_rd;
    if (s2_valid) begin
      acc <= s2_first ? SUM_W'(prod) : acc + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issuing   <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (out_take && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n_cur   <= size_eff;
            i       <= '0;
            j       <= '0;
            k       <= '0;
            issuing <= 1'b1;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (k == n_last) begin
              issuing <= 1'b0;
            end else begin
              k <= k + 1'b1;
            end
          end
          if (s2_valid && s2_last) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_row        <= i;
            out_col        <= j;
            product_value  <= acc;
            last_of_matrix <= (i == n_last) && (j == n_last);
            if ((i == n_last) && (j == n_last)) begin
              state <= ST_IDLE;
            end else begin
              if (j == n_last) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
              k       <= '0;
              issuing <= 1'b1;
              state   <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty = !out_valid;

endmodule

### dv/tb_square_matrix_multiply.sv
module tb_square_matrix_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  import smm_pkg::*;

  localparam int DIM            = 8;
  localparam int RANDOM_ITEMS   = 420;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  localparam action_t ACT_UNUSED = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [SUM_W-1:0] value;
    logic                    last;
  } product_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  action_t                  action = ACT_LOAD_A;
  logic [IDX_W-1:0]         row = '0;
  logic [IDX_W-1:0]         col = '0;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [SUM_W-1:0]  product_value;
  logic                     last_of_matrix;
  logic                     matrix_size_we = 1'b0;
  logic [SIZE_W-1:0]        matrix_size = '0;

  logic [ELEM_W-1:0] a_store [DIM*DIM];
  logic [ELEM_W-1:0] b_store [DIM*DIM];
  bit [DIM*DIM-1:0]  a_loaded = '0;
  bit [DIM*DIM-1:0]  b_loaded = '0;
  logic [SIZE_W-1:0] size_reg = 4'd8;
  product_t          expected_products [$];
  int                mismatches = 0;
  int                stuck_cycles = 0;
  bit                hold_off_req = 1'b0;

  square_matrix_multiply #(.MAX_SIZE(DIM)) dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action         (action),
    .row            (row),
    .col            (col),
    .element_value  (element_value),
    .empty          (empty),
    .pop            (pop),
    .out_row        (out_row),
    .out_col        (out_col),
    .product_value  (product_value),
    .last_of_matrix (last_of_matrix),
    .matrix_size_we (matrix_size_we),
    .matrix_size    (matrix_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int size_in_use();
    if (size_reg == 0) return 1;
    if (size_reg > DIM) return DIM;
    return int'(size_reg);
  endfunction

  function automatic void predict_products(action_t act, logic [IDX_W-1:0] r,
                                           logic [IDX_W-1:0] c, logic [ELEM_W-1:0] v);
    int       n;
    longint   acc;
    product_t p;
    case (act)
      ACT_LOAD_A: begin
        a_store[r*DIM+c] = v;
        a_loaded[r*DIM+c] = 1'b1;
      end
      ACT_LOAD_B: begin
        b_store[r*DIM+c] = v;
        b_loaded[r*DIM+c] = 1'b1;
      end
      ACT_COMPUTE: begin
        n = size_in_use();
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
              acc += longint'($signed(a_store[i*DIM+k])) *
                     longint'($signed(b_store[k*DIM+j]));
            p.r = i[IDX_W-1:0];
            p.c = j[IDX_W-1:0];
            p.value = acc[SUM_W-1:0];
            p.last = (i == n - 1) && (j == n - 1);
            expected_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // first entry within size n not yet loaded in A or B
  function automatic bit find_gap(int n, output bit to_b, output int r, output int c);
    to_b = 1'b0;
    r = 0;
    c = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!a_loaded[i*DIM+j] || !b_loaded[i*DIM+j]) begin
          to_b = a_loaded[i*DIM+j];
          r = i;
          c = j;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return ELEM_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_request(action_t act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                              logic [ELEM_W-1:0] v);
    @(negedge clk);
    push <= 1'b1;
    action <= act;
    row <= r;
    col <= c;
    element_value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_products(act, r, c, v);
  endtask

  task automatic idle_cycles(int k);
    repeat (k) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    wait_drained();
    @(negedge clk);
    matrix_size_we <= 1'b1;
    matrix_size <= v;
    @(negedge clk);
    matrix_size_we <= 1'b0;
    size_reg = v;
  endtask

  task automatic test_directed();
    write_size(4'd1);
    send_request(ACT_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
    send_request(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_request(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_request(ACT_LOAD_A, 3'd0, 3'd0, 16'h8000);
    // index and value fields are don't-care on compute
    send_request(ACT_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
    send_request(ACT_UNUSED, 3'd5, 3'd2, 16'h1234);
    // stored but beyond the size in use
    send_request(ACT_LOAD_A, 3'd7, 3'd7, 16'h0100);
    write_size(4'd0);
    send_request(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
    write_size(4'd2);
    send_request(ACT_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_request(ACT_LOAD_A, 3'd0, 3'd1, 16'h8000);
    send_request(ACT_LOAD_A, 3'd1, 3'd0, 16'h7FFF);
    send_request(ACT_LOAD_A, 3'd1, 3'd1, 16'hFFFF);
    send_request(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_request(ACT_LOAD_B, 3'd0, 3'd1, 16'h7FFF);
    send_request(ACT_LOAD_B, 3'd1, 3'd0, 16'h8000);
    send_request(ACT_LOAD_B, 3'd1, 3'd1, 16'h0001);
    send_request(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
  endtask

  task automatic test_random_mix();
    logic [SIZE_W-1:0] size_choices [14] = '{4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
                                             4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd15};
    int  sent;
    int  phase_left;
    int  burst_left;
    int  n;
    int  pick;
    int  r;
    int  c;
    bit  to_b;
    sent = 0;
    phase_left = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        write_size(size_choices[$urandom_range(0, 13)]);
        phase_left = $urandom_range(20, 60);
      end
      n = size_in_use();
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(ACT_UNUSED, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                     rand_element());
      end else begin
        if (pick < 3 + 100 / (n * n + 2)) begin
          if (find_gap(n, to_b, r, c))
            send_request(to_b ? ACT_LOAD_B : ACT_LOAD_A, IDX_W'(r), IDX_W'(c),
                         rand_element());
          else
            send_request(ACT_COMPUTE, IDX_W'($urandom_range(0, 7)),
                         IDX_W'($urandom_range(0, 7)), rand_element());
        end else begin
          if ($urandom_range(0, 99) < 85) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
          end else begin
            r = $urandom_range(0, DIM - 1);
            c = $urandom_range(0, DIM - 1);
          end
          send_request($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A, IDX_W'(r), IDX_W'(c),
                       rand_element());
        end
        sent++;
        phase_left--;
      end
    end
  endtask

  task automatic test_backpressure();
    int r;
    int c;
    bit to_b;
    write_size(4'd15);
    while (find_gap(DIM, to_b, r, c))
      send_request(to_b ? ACT_LOAD_B : ACT_LOAD_A, IDX_W'(r), IDX_W'(c), rand_element());
    hold_off_req = 1'b1;
    send_request(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
    repeat (24)
      send_request($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A,
                   IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                   rand_element());
    send_request(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
  endtask

  initial begin : receiver
    int rx_mode;
    int cyc;
    rx_mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (cyc % 48 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 1);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cyc % 32) < 8;
        endcase
        cyc++;
      end
    end
  end

  always @(posedge clk) begin : check_results
    product_t want;
    if (!rst && pop && !empty) begin
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected product row %0d col %0d value %0d last %0b",
                   $time, out_row, out_col, product_value, last_of_matrix);
      end else begin
        want = expected_products.pop_front();
        if (out_row !== want.r || out_col !== want.c || product_value !== want.value ||
            last_of_matrix !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: product mismatch exp row %0d col %0d value %0d last %0b",
                     $time, want.r, want.c, want.value, want.last,
                     " / got row %0d col %0d value %0d last %0b",
                     out_row, out_col, product_value, last_of_matrix);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_square_matrix_multiply: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("tb_square_matrix_multiply: clean");
    end else begin
      $display("tb_square_matrix_multiply: errors");
    end
    $finish;
  end

endmodule
